// ===== src/bmpmi_pkg.sv =====
package bmpmi_pkg;

    // Icon geometry
    localparam int ICON_WIDTH = 30;
    localparam int ICON_ROWS  = 19;

    localparam int POS_W = 7;

    // Pixel depth codes
    typedef enum logic [1:0] {
        DEPTH_1  = 2'd0,
        DEPTH_16 = 2'd1,
        DEPTH_24 = 2'd2,
        DEPTH_32 = 2'd3
    } depth_t;

    // Row stride in bytes, padded to four
    localparam int STRIDE_1  = (((ICON_WIDTH * 1  + 7) / 8 + 3) / 4) * 4;
    localparam int STRIDE_16 = (((ICON_WIDTH * 16 + 7) / 8 + 3) / 4) * 4;
    localparam int STRIDE_24 = (((ICON_WIDTH * 24 + 7) / 8 + 3) / 4) * 4;
    localparam int STRIDE_32 = (((ICON_WIDTH * 32 + 7) / 8 + 3) / 4) * 4;

    // Pixel columns that exist in the icon, MSB first
    localparam logic [31:0] WIDTH_MASK = ~(32'hFFFF_FFFF >> ICON_WIDTH);

    localparam logic [9:0] SUM_WHITE    = 10'd765;
    localparam logic [9:0] SUM_BLACK_LT = 10'd384;
    localparam logic [6:0] S16_BLACK_LT = 7'd23;

    // Per-byte result of the pixel unit
    typedef struct packed {
        logic [15:0] sum_next;
        logic [31:0] set_bits;
        logic        warn;
    } pix_t;

    function automatic logic [7:0] stride_of(depth_t mode);
        logic [7:0] s;
        unique case (mode)
            DEPTH_1:  s = 8'(STRIDE_1);
            DEPTH_16: s = 8'(STRIDE_16);
            DEPTH_24: s = 8'(STRIDE_24);
            DEPTH_32: s = 8'(STRIDE_32);
            default:  s = 8'(STRIDE_1);
        endcase
        return s;
    endfunction

endpackage

// ===== src/bmpmi_pixel.sv =====
module bmpmi_pixel (
    input  logic [7:0]                    pixel_byte,
    input  bmpmi_pkg::depth_t             mode,
    input  logic [bmpmi_pkg::POS_W-1:0]   pos,
    input  logic [15:0]                   channel_sum,
    output bmpmi_pkg::pix_t               pix
);
    import bmpmi_pkg::*;

    logic [12:0] prod3;
    logic [5:0]  x3;
    logic [7:0]  rem3;
    logic [1:0]  k;
    logic [1:0]  k_last;
    logic [5:0]  x;
    logic [15:0] base;
    logic [15:0] sum;
    logic [15:0] w;
    logic [6:0]  s16;
    logic        black;
    logic        pix_done;
    logic        warn;
    logic [31:0] bit_mask;
    logic [31:0] byte_mask;

    // pos / 3 by reciprocal: exact for pos < 128
    assign prod3 = 13'(pos) * 13'd43;
    assign x3    = prod3[12:7];
    assign rem3  = 8'(pos) - 8'({x3, 1'b0}) - 8'(x3);

    assign w   = {pixel_byte, channel_sum[7:0]};
    assign s16 = 7'(w[14:12]) + 7'(w[9:5]) + 7'(w[4:0]);

    // 1 bpp: eight pixels at once, only the first four bytes land in the row
    assign byte_mask = (pos[6:2] == 5'd0)
                     ? (({pixel_byte, 24'h0} >> {pos[1:0], 3'b000}) & WIDTH_MASK)
                     : 32'h0;

    always_comb
    begin
        k      = 2'd0;
        k_last = 2'd0;
        x      = 6'd0;
        unique case (mode)
            DEPTH_1:
            begin
                k      = 2'd0;
                k_last = 2'd0;
                x      = 6'd0;
            end
            DEPTH_16:
            begin
                k      = {1'b0, pos[0]};
                k_last = 2'd1;
                x      = pos[6:1];
            end
            DEPTH_24:
            begin
                k      = rem3[1:0];
                k_last = 2'd2;
                x      = x3;
            end
            DEPTH_32:
            begin
                k      = pos[1:0];
                k_last = 2'd3;
                x      = {1'b0, pos[6:2]};
            end
            default:
            begin
                k      = 2'd0;
                k_last = 2'd0;
                x      = 6'd0;
            end
        endcase
    end

    always_comb
    begin
        base     = (k == 2'd0) ? 16'h0 : channel_sum;
        sum      = channel_sum;
        black    = 1'b0;
        pix_done = 1'b0;
        warn     = 1'b0;
        unique case (mode)
            DEPTH_1:
            begin
                sum = channel_sum;
            end
            DEPTH_16:
            begin
                if (k == 2'd0)
                begin
                    sum = 16'(pixel_byte);
                end
                else
                begin
                    sum      = channel_sum;
                    pix_done = 1'b1;
                    black    = (s16 < S16_BLACK_LT);
                end
            end
            DEPTH_24, DEPTH_32:
            begin
                // 32 bpp: leading X/A byte is not a color channel
                if (mode == DEPTH_32 && k == 2'd0)
                    sum = base;
                else
                    sum = base + 16'(pixel_byte);
                if (k == k_last)
                begin
                    pix_done = 1'b1;
                    black    = (sum < 16'(SUM_BLACK_LT));
                    warn     = (sum != 16'h0) && (sum != 16'(SUM_WHITE));
                end
            end
            default:
            begin
                sum = channel_sum;
            end
        endcase
    end

    assign bit_mask = (pix_done && black && !x[5])
                    ? ((32'h8000_0000 >> x[4:0]) & WIDTH_MASK)
                    : 32'h0;

    assign pix = '{sum_next: sum,
                   set_bits: (mode == DEPTH_1) ? byte_mask : bit_mask,
                   warn:     warn};

endmodule

// ===== src/bmp_rows_to_mono_icon.sv =====
// bmp_rows_to_mono_icon: BMP pixel-array bytes to a 1 bpp icon, one row per beat out.
// The beat carrying a row's last byte passes one input register stage, then its row beat
//   is set in the result register.
// Throughput: one byte per cycle, unless a row's last byte meets a row beat held by out_stall;
//   the output register lets the next row's other bytes in while a row beat waits on out_stall.
// Reset (rst_n low, async): depth 1 bpp, counters, row accumulator and warning cleared.
module bmp_rows_to_mono_icon (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                depth_mode,
    // byte input
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                pixel_byte,
    // row output
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [31:0]               row_bits,
    output logic [4:0]                row_number,
    output logic                      color_warning,
    output logic                      frame_done
);
    import bmpmi_pkg::*;

    // configuration
    depth_t            mode_reg;

    // input stage
    logic              s1_valid_reg;
    logic [7:0]        s1_byte_reg;

    // row state
    logic [POS_W-1:0]  row_byte_pos_reg, row_byte_pos_next;
    logic [15:0]       channel_sum_reg, channel_sum_next;
    logic [31:0]       row_accum_reg, row_accum_next;
    logic [4:0]        rows_done_reg, rows_done_next;
    logic              warn_reg, warn_next;

    // result register
    logic              out_valid_reg;
    logic [31:0]       row_bits_reg;
    logic [4:0]        row_number_reg;
    logic              warn_out_reg;
    logic              frame_done_reg;

    pix_t              pix;
    logic              row_end;
    logic              last_row;
    logic              s1_adv;
    logic              s1_load;
    logic [31:0]       row_full;
    logic              warn_now;

    assign cfg_ready = 1'b1;

    bmpmi_pixel u_pixel (
        .pixel_byte  (s1_byte_reg),
        .mode        (mode_reg),
        .pos         (row_byte_pos_reg),
        .channel_sum (channel_sum_reg),
        .pix         (pix)
    );

    // Row ends on the stride's last byte, or at once if a depth change left
    // the position past the new stride.
    assign row_end  = (({1'b0, row_byte_pos_reg} + 8'd1) >= stride_of(mode_reg));
    assign last_row = ((6'(rows_done_reg) + 6'd1) >= 6'(ICON_ROWS));
    assign row_full = row_accum_reg | pix.set_bits;
    assign warn_now = warn_reg | pix.warn;

    // Byte stage moves on unless it would emit into a held result beat.
    assign s1_adv   = s1_valid_reg && (!row_end || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign s1_load  = in_valid && !in_stall;

    always_comb
    begin
        row_byte_pos_next = row_byte_pos_reg;
        channel_sum_next  = channel_sum_reg;
        row_accum_next    = row_accum_reg;
        rows_done_next    = rows_done_reg;
        warn_next         = warn_reg;
        if (s1_adv)
        begin
            if (row_end)
            begin
                row_byte_pos_next = '0;
                channel_sum_next  = 16'h0;
                row_accum_next    = 32'h0;
                if (last_row)
                begin
                    rows_done_next = 5'd0;
                    warn_next      = 1'b0;
                end
                else
                begin
                    rows_done_next = rows_done_reg + 5'd1;
                    warn_next      = warn_now;
                end
            end
            else
            begin
                row_byte_pos_next = row_byte_pos_reg + POS_W'(1);
                channel_sum_next  = pix.sum_next;
                row_accum_next    = row_full;
                warn_next         = warn_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= DEPTH_1;
            s1_valid_reg     <= 1'b0;
            row_byte_pos_reg <= '0;
            channel_sum_reg  <= 16'h0;
            row_accum_reg    <= 32'h0;
            rows_done_reg    <= 5'd0;
            warn_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode_reg <= depth_t'(depth_mode);
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            row_byte_pos_reg <= row_byte_pos_next;
            channel_sum_reg  <= channel_sum_next;
            row_accum_reg    <= row_accum_next;
            rows_done_reg    <= rows_done_next;
            warn_reg         <= warn_next;
            if (s1_adv && row_end)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_byte_reg <= pixel_byte;
        if (s1_adv && row_end)
        begin
            // top row: first byte of the frame's last row forced to zero
            row_bits_reg   <= last_row ? (row_full & 32'h00FF_FFFF) : row_full;
            row_number_reg <= 5'(ICON_ROWS - 1) - rows_done_reg;
            warn_out_reg   <= warn_now;
            frame_done_reg <= last_row;
        end
    end

    assign out_valid     = out_valid_reg;
    assign row_bits      = row_bits_reg;
    assign row_number    = row_number_reg;
    assign color_warning = warn_out_reg;
    assign frame_done    = frame_done_reg;

endmodule

// ===== src/bmpmi_checker.sv =====
module bmpmi_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] row_bits,
    input  logic [4:0]  row_number,
    input  logic        frame_done
);
    import bmpmi_pkg::*;

    // held beat keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_bits) && $stable(row_number))
        else $error("row beat changed while stalled");

    a_top_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> row_number == 5'd0 && row_bits[31:24] == 8'h00)
        else $error("top row not numbered zero or first byte not cleared");

    a_done_num: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_number == 5'd0 |-> frame_done)
        else $error("row zero without frame_done");

    a_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (row_bits & ~WIDTH_MASK) == 32'h0)
        else $error("bits set past icon width");

endmodule

bind bmp_rows_to_mono_icon bmpmi_checker u_bmpmi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row_bits   (row_bits),
    .row_number (row_number),
    .frame_done (frame_done)
);
